@@ sv/tscj_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the thumb-shift chord judge.
// Used by every module of the block but tscj_ram; depends on nothing.
package tscj_pkg;

  localparam int unsigned PENDING_DEPTH_DEFAULT = 8;
  localparam int unsigned PEND_WIDTH            = 17;

  localparam logic [15:0] TIMEOUT_RESET = 16'd150;
  localparam logic [15:0] OVERLAP_RESET = 16'd20;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_OVERLAP = 1'b1;

  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TIMER   = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [1:0] CLS_OUTSIDE = 2'd0;
  localparam logic [1:0] CLS_CHAR    = 2'd1;
  localparam logic [1:0] CLS_THUMB   = 2'd2;
  localparam logic [1:0] CLS_OTHER   = 2'd3;

  localparam logic [2:0] KIND_DONE       = 3'd0;
  localparam logic [2:0] KIND_CHAR_DOWN  = 3'd1;
  localparam logic [2:0] KIND_CHAR_UP    = 3'd2;
  localparam logic [2:0] KIND_THUMB_DOWN = 3'd3;
  localparam logic [2:0] KIND_THUMB_UP   = 3'd4;
  localparam logic [2:0] KIND_COMBO_DOWN = 3'd5;
  localparam logic [2:0] KIND_COMBO_UP   = 3'd6;
  localparam logic [2:0] KIND_REPLAY     = 3'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  key_class;
    logic [15:0] key_code;
    logic [15:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] char_code;
    logic [15:0] thumb_code;
    logic [15:0] replay_code;
    logic        replay_pressed;
    logic        consumed;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_C,
    PH_T,
    PH_CT,
    PH_TC
  } phase_e;

  typedef enum logic [2:0] {
    PRIM_CU,
    PRIM_TU,
    PRIM_MU,
    PRIM_CD,
    PRIM_TD,
    PRIM_MD
  } prim_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DOWN,
    ACT_UP
  } act_e;

  typedef enum logic [1:0] {
    TGT_C,
    TGT_T,
    TGT_M
  } tgt_e;

  typedef enum logic [2:0] {
    STEP_CO_C,
    STEP_CO_T,
    STEP_CO_M,
    STEP_DN,
    STEP_UP,
    STEP_END
  } step_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DIFF,
    CS_JUDGE,
    CS_STEP,
    CS_FLUSH_RD,
    CS_FLUSH_EMIT,
    CS_COMMIT,
    CS_DONE
  } ctl_state_e;

  typedef struct packed {
    phase_e next_phase;
    logic   load_char;
    logic   load_thumb;
    logic   clear_all;
    logic   buffer;
    logic   consumed;
  } commit_t;

  typedef struct packed {
    logic    latch;
    logic    diff;
    logic    prim_en;
    prim_e   prim;
    logic    replay_rd;
    logic    replay_emit;
    logic    commit;
    logic    done_emit;
    commit_t plan;
  } dp_cmd_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] command;
    logic [1:0] key_class;
    logic       match_char;
    logic       match_thumb;
    logic       late_char;
    logic       late_thumb;
    logic       ct_earlier;
    logic       tc_earlier;
    logic       ct_split;
    logic       tc_split;
    logic       sent_char;
    logic       sent_thumb;
    logic       sent_combo;
    logic       char_valid;
    logic       thumb_valid;
    logic       fill_nz;
    logic       replay_last;
    logic       out_free;
  } dp_status_t;

endpackage

@@ sv/tscj_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the buffered other-key requests.
module tscj_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tscj_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the chord judge: judges each request and sequences the actions.
// Depends on tscj_pkg; drives the datapath through dp_cmd_t.
module tscj_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tscj_pkg::dp_status_t status_i,
  output tscj_pkg::dp_cmd_t    cmd_o
);
  import tscj_pkg::*;

  ctl_state_e state_q, state_d;
  step_e      step_q, step_d;
  act_e       act_q, act_d;
  tgt_e       tgt_q, tgt_d;
  commit_t    plan_q, plan_d;

  act_e    jact;
  tgt_e    jtgt;
  commit_t jplan;
  logic    is_other;
  logic    need_down;
  logic    guard;
  prim_e   step_prim;
  step_e   step_next;

  always_comb begin
    jact  = ACT_NONE;
    jtgt  = TGT_C;
    jplan = '0;
    jplan.next_phase = status_i.phase;
    jplan.consumed   = 1'b1;
    is_other = 1'b0;
    case (status_i.command)
      CMD_TIMER: begin
        case (status_i.phase)
          PH_C: begin
            jact = ACT_DOWN; jtgt = TGT_C;
          end
          PH_T: begin
            jact = ACT_DOWN; jtgt = TGT_T;
          end
          PH_CT, PH_TC: begin
            jact = ACT_DOWN; jtgt = TGT_M;
          end
          default: ;
        endcase
      end
      CMD_CLEAR: begin
        jplan.clear_all  = 1'b1;
        jplan.next_phase = PH_IDLE;
        case (status_i.phase)
          PH_C: begin
            jact = ACT_UP; jtgt = TGT_C;
          end
          PH_T: begin
            jact = ACT_UP; jtgt = TGT_T;
          end
          PH_CT, PH_TC: begin
            jact = ACT_UP; jtgt = TGT_M;
          end
          default: ;
        endcase
      end
      CMD_PRESS: begin
        if (status_i.key_class == CLS_CHAR) begin
          jplan.load_char = 1'b1;
          case (status_i.phase)
            PH_IDLE: jplan.next_phase = PH_C;
            PH_C: begin
              jact = ACT_UP; jtgt = TGT_C;
            end
            PH_T: begin
              if (status_i.late_thumb) begin
                jact = ACT_UP; jtgt = TGT_T; jplan.next_phase = PH_C;
              end else begin
                jplan.next_phase = PH_TC;
              end
            end
            PH_CT: begin
              jact = ACT_UP;
              if (status_i.late_thumb || status_i.ct_earlier) begin
                jtgt = TGT_M; jplan.next_phase = PH_C;
              end else begin
                jtgt = TGT_C; jplan.next_phase = PH_TC;
              end
            end
            default: begin
              jact = ACT_UP; jtgt = TGT_M; jplan.next_phase = PH_C;
            end
          endcase
        end else if (status_i.key_class == CLS_THUMB) begin
          jplan.load_thumb = 1'b1;
          case (status_i.phase)
            PH_IDLE: jplan.next_phase = PH_T;
            PH_C: begin
              if (status_i.late_char) begin
                jact = ACT_UP; jtgt = TGT_C; jplan.next_phase = PH_T;
              end else begin
                jplan.next_phase = PH_CT;
              end
            end
            PH_T: begin
              jact = ACT_UP; jtgt = TGT_T;
            end
            PH_CT: begin
              jact = ACT_UP; jtgt = TGT_M; jplan.next_phase = PH_T;
            end
            default: begin
              jact = ACT_UP;
              if (status_i.late_char || status_i.tc_earlier) begin
                jtgt = TGT_M; jplan.next_phase = PH_T;
              end else begin
                jtgt = TGT_T; jplan.next_phase = PH_CT;
              end
            end
          endcase
        end else begin
          is_other = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (status_i.key_class != CLS_OUTSIDE) begin
          case (status_i.phase)
            PH_C: begin
              if (status_i.match_char) begin
                jact = ACT_UP; jtgt = TGT_C; jplan.next_phase = PH_IDLE;
              end
            end
            PH_T: begin
              if (status_i.match_thumb) begin
                jact = ACT_UP; jtgt = TGT_T; jplan.next_phase = PH_IDLE;
              end
            end
            PH_CT: begin
              if (status_i.match_char && status_i.ct_split) begin
                jact = ACT_UP; jtgt = TGT_C; jplan.next_phase = PH_T;
              end else if (status_i.match_char || status_i.match_thumb) begin
                jact = ACT_UP; jtgt = TGT_M; jplan.next_phase = PH_IDLE;
              end
            end
            PH_TC: begin
              if (status_i.match_thumb && status_i.tc_split) begin
                jact = ACT_UP; jtgt = TGT_T; jplan.next_phase = PH_C;
              end else if (status_i.match_thumb || status_i.match_char) begin
                jact = ACT_UP; jtgt = TGT_M; jplan.next_phase = PH_IDLE;
              end
            end
            default: ;
          endcase
        end else begin
          is_other = 1'b1;
        end
      end
      default: ;
    endcase
    if (is_other) begin
      if (status_i.phase == PH_IDLE) begin
        jplan.consumed = 1'b0;
      end else begin
        jplan.buffer = 1'b1;
      end
    end
  end

  always_comb begin
    case (jtgt)
      TGT_C:   need_down = !status_i.sent_char && status_i.char_valid;
      TGT_T:   need_down = !status_i.sent_thumb && status_i.thumb_valid;
      default: need_down = !status_i.sent_combo && status_i.char_valid && status_i.thumb_valid;
    endcase
  end

  always_comb begin
    case (step_q)
      STEP_CO_C: begin
        step_prim = PRIM_CU; guard = status_i.sent_char; step_next = STEP_CO_T;
      end
      STEP_CO_T: begin
        step_prim = PRIM_TU; guard = status_i.sent_thumb; step_next = STEP_CO_M;
      end
      STEP_CO_M: begin
        step_prim = PRIM_MU; guard = status_i.sent_combo; step_next = STEP_DN;
      end
      STEP_DN: begin
        case (tgt_q)
          TGT_C:   step_prim = PRIM_CD;
          TGT_T:   step_prim = PRIM_TD;
          default: step_prim = PRIM_MD;
        endcase
        guard     = 1'b1;
        step_next = (act_q == ACT_UP) ? STEP_UP : STEP_END;
      end
      STEP_UP: begin
        case (tgt_q)
          TGT_C:   step_prim = PRIM_CU;
          TGT_T:   step_prim = PRIM_TU;
          default: step_prim = PRIM_MU;
        endcase
        guard     = 1'b1;
        step_next = STEP_END;
      end
      default: begin
        step_prim = PRIM_CU; guard = 1'b0; step_next = STEP_END;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    act_d      = act_q;
    tgt_d      = tgt_q;
    plan_d     = plan_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.prim = step_prim;
    cmd_o.plan = plan_q;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = CS_DIFF;
        end
      end
      CS_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = CS_JUDGE;
      end
      CS_JUDGE: begin
        act_d  = jact;
        tgt_d  = jtgt;
        plan_d = jplan;
        if (jact == ACT_NONE) begin
          state_d = CS_COMMIT;
        end else begin
          state_d = CS_STEP;
          step_d  = (jact == ACT_UP && !need_down) ? STEP_UP : STEP_CO_C;
        end
      end
      CS_STEP: begin
        if (step_q == STEP_END) begin
          state_d = CS_COMMIT;
        end else if (!guard) begin
          step_d = step_next;
        end else if (status_i.out_free) begin
          cmd_o.prim_en = 1'b1;
          step_d        = step_next;
          if (status_i.fill_nz) begin
            state_d = CS_FLUSH_RD;
          end
        end
      end
      CS_FLUSH_RD: begin
        cmd_o.replay_rd = 1'b1;
        state_d         = CS_FLUSH_EMIT;
      end
      CS_FLUSH_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.replay_emit = 1'b1;
          state_d = status_i.replay_last ? CS_STEP : CS_FLUSH_RD;
        end
      end
      CS_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = CS_DONE;
      end
      CS_DONE: begin
        if (status_i.out_free) begin
          cmd_o.done_emit = 1'b1;
          state_d         = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      step_q  <= STEP_END;
      act_q   <= ACT_NONE;
      tgt_q   <= TGT_C;
      plan_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      act_q   <= act_d;
      tgt_q   <= tgt_d;
      plan_q  <= plan_d;
    end
  end

endmodule

@@ sv/tscj_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the chord judge: held keys, time differences, flags, replay buffer, result register.
// Depends on tscj_pkg and tscj_ram; obeys dp_cmd_t from tscj_ctrl.
module tscj_dp #(
  parameter int unsigned PENDING_DEPTH = tscj_pkg::PENDING_DEPTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tscj_pkg::dp_cmd_t    cmd_i,
  output tscj_pkg::dp_status_t status_o,
  input  tscj_pkg::in_item_t   in_item_i,
  input  logic [15:0]          timeout_i,
  input  logic [15:0]          overlap_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output tscj_pkg::out_item_t  out_item_o
);
  import tscj_pkg::*;

  localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(PENDING_DEPTH + 1);

  in_item_t  item_q;
  phase_e    phase_q, phase_d;
  logic [15:0] held_char_q, held_char_d, held_thumb_q, held_thumb_d;
  logic [15:0] char_stamp_q, char_stamp_d, thumb_stamp_q, thumb_stamp_d;
  logic      sc_q, sc_d, st_q, st_d, sm_q, sm_d, cv_q, cv_d, tv_q, tv_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [15:0] d_now_ts_q, d_now_cs_q, d_ts_cs_q, d_cs_ts_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic                  out_free;
  logic                  replay_last;
  logic                  ram_we;
  logic [PEND_WIDTH-1:0] ram_wdata;
  logic [PEND_WIDTH-1:0] ram_rdata;
  logic                  put;
  out_item_t             put_item;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign replay_last = (FW'(rp_q) + FW'(1)) == fill_q;
  assign ram_we      = cmd_i.commit && cmd_i.plan.buffer && (fill_q < FW'(PENDING_DEPTH));
  assign ram_wdata   = {item_q.command == CMD_PRESS, item_q.key_code};

  tscj_ram #(
    .WIDTH (PEND_WIDTH),
    .DEPTH (PENDING_DEPTH)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.replay_rd),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    status_o             = '0;
    status_o.phase       = phase_q;
    status_o.command     = item_q.command;
    status_o.key_class   = item_q.key_class;
    status_o.match_char  = cv_q && (held_char_q == item_q.key_code);
    status_o.match_thumb = tv_q && (held_thumb_q == item_q.key_code);
    status_o.late_char   = d_now_cs_q > timeout_i;
    status_o.late_thumb  = d_now_ts_q > timeout_i;
    status_o.ct_earlier  = d_ts_cs_q < d_now_ts_q;
    status_o.tc_earlier  = d_cs_ts_q < d_now_cs_q;
    status_o.ct_split    = !(d_ts_cs_q < d_now_ts_q) && (d_now_ts_q < overlap_i);
    status_o.tc_split    = !(d_cs_ts_q < d_now_cs_q) && (d_now_cs_q < overlap_i);
    status_o.sent_char   = sc_q;
    status_o.sent_thumb  = st_q;
    status_o.sent_combo  = sm_q;
    status_o.char_valid  = cv_q;
    status_o.thumb_valid = tv_q;
    status_o.fill_nz     = fill_q != '0;
    status_o.replay_last = replay_last;
    status_o.out_free    = out_free;
  end

  always_comb begin
    put      = 1'b0;
    put_item = '0;
    case (cmd_i.prim)
      PRIM_CU: begin
        put = cv_q; put_item.kind = KIND_CHAR_UP; put_item.char_code = held_char_q;
      end
      PRIM_TU: begin
        put = tv_q; put_item.kind = KIND_THUMB_UP; put_item.thumb_code = held_thumb_q;
      end
      PRIM_MU: begin
        put = cv_q && tv_q; put_item.kind = KIND_COMBO_UP;
        put_item.char_code = held_char_q; put_item.thumb_code = held_thumb_q;
      end
      PRIM_CD: begin
        put = cv_q; put_item.kind = KIND_CHAR_DOWN; put_item.char_code = held_char_q;
      end
      PRIM_TD: begin
        put = tv_q; put_item.kind = KIND_THUMB_DOWN; put_item.thumb_code = held_thumb_q;
      end
      PRIM_MD: begin
        put = cv_q && tv_q; put_item.kind = KIND_COMBO_DOWN;
        put_item.char_code = held_char_q; put_item.thumb_code = held_thumb_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d       = phase_q;
    held_char_d   = held_char_q;
    held_thumb_d  = held_thumb_q;
    char_stamp_d  = char_stamp_q;
    thumb_stamp_d = thumb_stamp_q;
    sc_d = sc_q; st_d = st_q; sm_d = sm_q; cv_d = cv_q; tv_d = tv_q;
    fill_d      = fill_q;
    rp_d        = rp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cmd_i.prim_en) begin
      if (put) begin
        out_valid_d = 1'b1;
        out_d       = put_item;
      end
      case (cmd_i.prim)
        PRIM_CU: begin
          sc_d = 1'b0; cv_d = 1'b0;
        end
        PRIM_TU: begin
          st_d = 1'b0; tv_d = 1'b0;
        end
        PRIM_MU: begin
          sm_d = 1'b0; cv_d = 1'b0; tv_d = 1'b0;
        end
        PRIM_CD: sc_d = 1'b1;
        PRIM_TD: st_d = 1'b1;
        PRIM_MD: sm_d = 1'b1;
        default: ;
      endcase
    end
    if (cmd_i.replay_emit) begin
      out_valid_d          = 1'b1;
      out_d                = '0;
      out_d.kind           = KIND_REPLAY;
      out_d.replay_code    = ram_rdata[15:0];
      out_d.replay_pressed = ram_rdata[PEND_WIDTH-1];
      if (replay_last) begin
        rp_d   = '0;
        fill_d = '0;
      end else begin
        rp_d = rp_q + AW'(1);
      end
    end
    if (cmd_i.commit) begin
      phase_d = cmd_i.plan.next_phase;
      if (cmd_i.plan.clear_all) begin
        sc_d = 1'b0; st_d = 1'b0; sm_d = 1'b0; cv_d = 1'b0; tv_d = 1'b0;
      end
      if (cmd_i.plan.load_char) begin
        held_char_d  = item_q.key_code;
        char_stamp_d = item_q.time_ms;
        cv_d         = 1'b1;
      end
      if (cmd_i.plan.load_thumb) begin
        held_thumb_d  = item_q.key_code;
        thumb_stamp_d = item_q.time_ms;
        tv_d          = 1'b1;
      end
      if (ram_we) begin
        fill_d = fill_q + FW'(1);
      end
    end
    if (cmd_i.done_emit) begin
      out_valid_d    = 1'b1;
      out_d          = '0;
      out_d.kind     = KIND_DONE;
      out_d.consumed = cmd_i.plan.consumed;
      out_d.last     = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    if (cmd_i.diff) begin
      d_now_ts_q <= item_q.time_ms - thumb_stamp_q;
      d_now_cs_q <= item_q.time_ms - char_stamp_q;
      d_ts_cs_q  <= thumb_stamp_q - char_stamp_q;
      d_cs_ts_q  <= char_stamp_q - thumb_stamp_q;
    end
    held_char_q  <= held_char_d;
    held_thumb_q <= held_thumb_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      char_stamp_q  <= '0;
      thumb_stamp_q <= '0;
      sc_q          <= 1'b0;
      st_q          <= 1'b0;
      sm_q          <= 1'b0;
      cv_q          <= 1'b0;
      tv_q          <= 1'b0;
      fill_q        <= '0;
      rp_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      char_stamp_q  <= char_stamp_d;
      thumb_stamp_q <= thumb_stamp_d;
      sc_q          <= sc_d;
      st_q          <= st_d;
      sm_q          <= sm_d;
      cv_q          <= cv_d;
      tv_q          <= tv_d;
      fill_q        <= fill_d;
      rp_q          <= rp_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.prim_en || cmd_i.replay_emit || cmd_i.done_emit) |-> out_free)
    else $error("Result issued while the output register is still held.");

  a_replay_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.replay_rd |-> (fill_q != '0))
    else $error("Replay read issued with an empty buffer.");

  a_replay_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.replay_emit && replay_last) |=> (fill_q == '0))
    else $error("Buffer not emptied after its last replayed entry.");

endmodule

@@ sv/thumb_shift_chord_judge_unit.sv @@
`timescale 1ns / 1ps
// Top level of the thumb-shift chord judge: configuration registers and the two halves.
// Depends on tscj_pkg, tscj_ctrl and tscj_dp (which holds tscj_ram).
//
// Each key, timer or clear request is taken one at a time and answered by a sequence of
// results that always ends with a done item marked last. A request that causes no action
// passes through capture, time differences, judge, state update and the done result.
// An action walks its steps in order: held keys already sent are closed, the press is sent,
// then for a release action the release; a release whose press was already sent goes
// straight to the release. The state update and the done result follow. Every buffered
// other-key request is replayed by a read and then an emit, since the replay buffer is a
// single RAM with a registered read; at the default depth it holds up to eight requests.
// Output back-pressure holds the sequence until the result register is free.
module thumb_shift_chord_judge_unit #(
  parameter int unsigned PENDING_DEPTH = tscj_pkg::PENDING_DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tscj_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tscj_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tscj_pkg::*;

  logic [15:0] timeout_q, timeout_d;
  logic [15:0] overlap_q, overlap_d;
  logic        cfg_wr;
  dp_cmd_t     dp_cmd;
  dp_status_t  dp_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    timeout_d = timeout_q;
    overlap_d = overlap_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_TIMEOUT: timeout_d = pwdata[15:0];
        REG_OVERLAP: overlap_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIMEOUT: prdata = {16'd0, timeout_q};
      REG_OVERLAP: prdata = {16'd0, overlap_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      overlap_q <= OVERLAP_RESET;
    end else begin
      timeout_q <= timeout_d;
      overlap_q <= overlap_d;
    end
  end

  tscj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  tscj_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .in_item_i   (in_item_i),
    .timeout_i   (timeout_q),
    .overlap_i   (overlap_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

@@ dv/tscj_judge_checker.sv @@
`timescale 1ns / 1ps
// Checker for the thumb-shift chord judge: watches the request, result and register ports,
// predicts every result from its own copy of the chord state and compares field by field.
// Depends on tscj_pkg for the payload types and codes.
module tscj_judge_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  tscj_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  tscj_pkg::out_item_t out_item_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  input  logic                pready_i,
  output int                  fail_count_o,
  output int                  outstanding_o,
  output int                  results_checked_o
);
  import tscj_pkg::*;

  localparam int MAX_ACTIONS = 16;
  localparam int STASH_DEPTH = PENDING_DEPTH_DEFAULT;

  out_item_t   expected_actions [$];
  int          step_count;
  logic [15:0] tmo_ms;
  logic [15:0] ovl_ms;
  phase_e      ph;
  logic [15:0] char_key;
  logic [15:0] thumb_key;
  logic        char_held;
  logic        thumb_held;
  logic [15:0] char_t0;
  logic [15:0] thumb_t0;
  logic        char_sent;
  logic        thumb_sent;
  logic        combo_sent;
  logic [15:0] stash_code [STASH_DEPTH];
  logic        stash_press [STASH_DEPTH];
  int          stash_fill;

  function automatic logic [15:0] ms_since(input logic [15:0] a, input logic [15:0] b);
    return a - b;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count_o < 30) begin
      $display("[%0t] ERROR %s", $time, what);
    end
    fail_count_o++;
  endtask

  task automatic push_action(input logic [2:0] kind, input logic [15:0] ch, th, rp_code,
                             input logic rp_press, cons, fin);
    out_item_t a;
    if (step_count >= MAX_ACTIONS) return;
    if (!fin && step_count >= MAX_ACTIONS - 1) return;
    a.kind           = kind;
    a.char_code      = ch;
    a.thumb_code     = th;
    a.replay_code    = rp_code;
    a.replay_pressed = rp_press;
    a.consumed       = cons;
    a.last           = fin;
    expected_actions.push_back(a);
    step_count++;
  endtask

  task automatic replay_stash();
    for (int i = 0; i < stash_fill; i++) begin
      push_action(KIND_REPLAY, '0, '0, stash_code[i], stash_press[i], 1'b0, 1'b0);
    end
    stash_fill = 0;
  endtask

  task automatic char_up_now();
    if (char_held) push_action(KIND_CHAR_UP, char_key, '0, '0, 1'b0, 1'b0, 1'b0);
    char_sent = 1'b0;
    char_held = 1'b0;
    char_key  = '0;
    replay_stash();
  endtask

  task automatic thumb_up_now();
    if (thumb_held) push_action(KIND_THUMB_UP, '0, thumb_key, '0, 1'b0, 1'b0, 1'b0);
    thumb_sent = 1'b0;
    thumb_held = 1'b0;
    thumb_key  = '0;
    replay_stash();
  endtask

  task automatic combo_up_now();
    if (char_held && thumb_held) begin
      push_action(KIND_COMBO_UP, char_key, thumb_key, '0, 1'b0, 1'b0, 1'b0);
    end
    combo_sent = 1'b0;
    char_held  = 1'b0;
    thumb_held = 1'b0;
    char_key   = '0;
    thumb_key  = '0;
    replay_stash();
  endtask

  // Any down action first releases whatever was already pressed on the host side.
  task automatic close_sent();
    if (char_sent) char_up_now();
    if (thumb_sent) thumb_up_now();
    if (combo_sent) combo_up_now();
  endtask

  task automatic emit_char_down();
    close_sent();
    if (char_held) push_action(KIND_CHAR_DOWN, char_key, '0, '0, 1'b0, 1'b0, 1'b0);
    char_sent = 1'b1;
    replay_stash();
  endtask

  task automatic emit_thumb_down();
    close_sent();
    if (thumb_held) push_action(KIND_THUMB_DOWN, '0, thumb_key, '0, 1'b0, 1'b0, 1'b0);
    thumb_sent = 1'b1;
    replay_stash();
  endtask

  task automatic emit_combo_down();
    close_sent();
    if (char_held && thumb_held) begin
      push_action(KIND_COMBO_DOWN, char_key, thumb_key, '0, 1'b0, 1'b0, 1'b0);
    end
    combo_sent = 1'b1;
    replay_stash();
  endtask

  task automatic emit_char_up();
    if (!char_sent && char_held) emit_char_down();
    char_up_now();
  endtask

  task automatic emit_thumb_up();
    if (!thumb_sent && thumb_held) emit_thumb_down();
    thumb_up_now();
  endtask

  task automatic emit_combo_up();
    if (!combo_sent && char_held && thumb_held) emit_combo_down();
    combo_up_now();
  endtask

  task automatic judge_request(input in_item_t rq);
    logic        consumed;
    logic        hit_char;
    logic        hit_thumb;
    logic [15:0] lead;
    logic [15:0] lag;
    consumed   = 1'b1;
    step_count = 0;
    hit_char   = char_held && (char_key == rq.key_code);
    hit_thumb  = thumb_held && (thumb_key == rq.key_code);
    if (rq.command == CMD_TIMER) begin
      case (ph)
        PH_C:         emit_char_down();
        PH_T:         emit_thumb_down();
        PH_CT, PH_TC: emit_combo_down();
        default: ;
      endcase
    end else if (rq.command == CMD_CLEAR) begin
      case (ph)
        PH_C:         emit_char_up();
        PH_T:         emit_thumb_up();
        PH_CT, PH_TC: emit_combo_up();
        default: ;
      endcase
      char_key   = '0;
      thumb_key  = '0;
      char_held  = 1'b0;
      thumb_held = 1'b0;
      ph         = PH_IDLE;
      char_sent  = 1'b0;
      thumb_sent = 1'b0;
      combo_sent = 1'b0;
    end else if (rq.command == CMD_PRESS && rq.key_class == CLS_CHAR) begin
      case (ph)
        PH_IDLE: ph = PH_C;
        PH_C:    emit_char_up();
        PH_T: begin
          if (ms_since(rq.time_ms, thumb_t0) > tmo_ms) begin
            emit_thumb_up();
            ph = PH_C;
          end else begin
            ph = PH_TC;
          end
        end
        PH_CT: begin
          lead = ms_since(thumb_t0, char_t0);
          lag  = ms_since(rq.time_ms, thumb_t0);
          if (lag > tmo_ms || lead < lag) begin
            emit_combo_up();
            ph = PH_C;
          end else begin
            emit_char_up();
            ph = PH_TC;
          end
        end
        default: begin
          emit_combo_up();
          ph = PH_C;
        end
      endcase
      char_key  = rq.key_code;
      char_held = 1'b1;
      char_t0   = rq.time_ms;
    end else if (rq.command == CMD_PRESS && rq.key_class == CLS_THUMB) begin
      case (ph)
        PH_IDLE: ph = PH_T;
        PH_C: begin
          if (ms_since(rq.time_ms, char_t0) > tmo_ms) begin
            emit_char_up();
            ph = PH_T;
          end else begin
            ph = PH_CT;
          end
        end
        PH_T: emit_thumb_up();
        PH_CT: begin
          emit_combo_up();
          ph = PH_T;
        end
        default: begin
          lead = ms_since(char_t0, thumb_t0);
          lag  = ms_since(rq.time_ms, char_t0);
          if (lag > tmo_ms || lead < lag) begin
            emit_combo_up();
            ph = PH_T;
          end else begin
            emit_thumb_up();
            ph = PH_CT;
          end
        end
      endcase
      thumb_key  = rq.key_code;
      thumb_held = 1'b1;
      thumb_t0   = rq.time_ms;
    end else if (rq.command == CMD_RELEASE && rq.key_class != CLS_OUTSIDE) begin
      case (ph)
        PH_C: begin
          if (hit_char) begin
            emit_char_up();
            ph = PH_IDLE;
          end
        end
        PH_T: begin
          if (hit_thumb) begin
            emit_thumb_up();
            ph = PH_IDLE;
          end
        end
        PH_CT: begin
          lead = ms_since(thumb_t0, char_t0);
          lag  = ms_since(rq.time_ms, thumb_t0);
          if (hit_char && lead >= lag && lag < ovl_ms) begin
            emit_char_up();
            ph = PH_T;
          end else if (hit_char || hit_thumb) begin
            emit_combo_up();
            ph = PH_IDLE;
          end
        end
        PH_TC: begin
          lead = ms_since(char_t0, thumb_t0);
          lag  = ms_since(rq.time_ms, char_t0);
          if (hit_thumb && lead >= lag && lag < ovl_ms) begin
            emit_thumb_up();
            ph = PH_C;
          end else if (hit_char || hit_thumb) begin
            emit_combo_up();
            ph = PH_IDLE;
          end
        end
        default: ;
      endcase
    end else begin
      if (ph == PH_IDLE) begin
        consumed = 1'b0;
      end else if (stash_fill < STASH_DEPTH) begin
        stash_code[stash_fill]  = rq.key_code;
        stash_press[stash_fill] = (rq.command == CMD_PRESS);
        stash_fill++;
      end
    end
    push_action(KIND_DONE, '0, '0, '0, 1'b0, consumed, 1'b1);
  endtask

  task automatic check_action(input out_item_t got);
    out_item_t want;
    string     diffs;
    if (expected_actions.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with nothing expected", got));
      return;
    end
    want  = expected_actions.pop_front();
    diffs = "";
    if (got.kind !== want.kind) diffs = {diffs, " kind"};
    if (got.char_code !== want.char_code) diffs = {diffs, " char_code"};
    if (got.thumb_code !== want.thumb_code) diffs = {diffs, " thumb_code"};
    if (got.replay_code !== want.replay_code) diffs = {diffs, " replay_code"};
    if (got.replay_pressed !== want.replay_pressed) diffs = {diffs, " replay_pressed"};
    if (got.consumed !== want.consumed) diffs = {diffs, " consumed"};
    if (got.last !== want.last) diffs = {diffs, " last"};
    if (diffs != "") begin
      report_mismatch($sformatf("result %0d differs in%s: got %h, want %h",
                                results_checked_o, diffs, got, want));
    end
    results_checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_actions.delete();
      tmo_ms            = TIMEOUT_RESET;
      ovl_ms            = OVERLAP_RESET;
      ph                = PH_IDLE;
      char_key          = '0;
      thumb_key         = '0;
      char_held         = 1'b0;
      thumb_held        = 1'b0;
      char_t0           = '0;
      thumb_t0          = '0;
      char_sent         = 1'b0;
      thumb_sent        = 1'b0;
      combo_sent        = 1'b0;
      stash_fill        = 0;
      fail_count_o      = 0;
      results_checked_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_TIMEOUT) tmo_ms = pwdata_i[15:0];
          else ovl_ms = pwdata_i[15:0];
        end else if (prdata_i !== {16'h0, (paddr_i[2] == REG_TIMEOUT) ? tmo_ms : ovl_ms}) begin
          report_mismatch($sformatf("register read at %0d returned %h", paddr_i, prdata_i));
        end
      end
      if (in_valid_i && !in_stall_i) judge_request(in_item_i);
      if (out_valid_i && !out_stall_i) check_action(out_item_i);
    end
    outstanding_o = expected_actions.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the chord judge testbench: clock, reset, register set-up and key request stimulus.
// Depends on tscj_pkg, thumb_shift_chord_judge_unit and tscj_judge_checker.
module tb_top;
  import tscj_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 75;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          requests_sent = 0;
  logic [15:0] now_ms = '0;
  logic [15:0] tmo_cfg = TIMEOUT_RESET;
  int unsigned cycles = 0;
  int          fail_count;
  int          outstanding;
  int          results_checked;

  thumb_shift_chord_judge_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tscj_judge_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_item_i         (in_item),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_item_i        (out_item),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_i          (prdata),
    .pready_i          (pready),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles, outstanding);
      $display("thumb_shift_chord_judge_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] gap_ms();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom_range(0, 40));
      4, 5, 6:    return 16'($urandom_range(0, 400));
      7:          return tmo_cfg;
      8:          return tmo_cfg + 16'd1;
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] any_code();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request was taken.
  task automatic send_at(input logic [1:0] cmd, input logic [1:0] cls, input logic [15:0] code,
                         input logic [15:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    now_ms             = t;
    in_item.command   <= cmd;
    in_item.key_class <= cls;
    in_item.key_code  <= code;
    in_item.time_ms   <= t;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic send_next(input logic [1:0] cmd, input logic [1:0] cls, input logic [15:0] code);
    send_at(cmd, cls, code, now_ms + gap_ms());
  endtask

  task automatic apb_access(input logic wr, input logic sel, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Chord: a key and other keys; maybe second key, timer, third key; releases or clear.
  task automatic play_chord();
    logic [15:0] ck;
    logic [15:0] tk;
    logic [15:0] stray;
    logic        thumb_first;
    int          extras;
    ck = any_code();
    tk = any_code();
    if ($urandom_range(7) == 0) begin
      send_at(2'($urandom_range(3)), 2'($urandom_range(3)), any_code(), 16'($urandom));
      return;
    end
    thumb_first = 1'($urandom_range(1));
    send_next(CMD_PRESS, thumb_first ? CLS_THUMB : CLS_CHAR, thumb_first ? tk : ck);
    extras = ($urandom_range(3) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 2);
    repeat (extras) begin
      send_next($urandom_range(1) ? CMD_PRESS : CMD_RELEASE,
                $urandom_range(1) ? CLS_OUTSIDE : CLS_OTHER, any_code());
    end
    if ($urandom_range(3) != 0) begin
      send_next(CMD_PRESS, thumb_first ? CLS_CHAR : CLS_THUMB, thumb_first ? ck : tk);
    end
    if ($urandom_range(4) == 0) send_next(CMD_TIMER, 2'($urandom_range(3)), any_code());
    if ($urandom_range(4) == 0) begin
      stray = any_code();
      if ($urandom_range(1)) begin
        send_next(CMD_PRESS, CLS_CHAR, stray);
        ck = stray;
      end else begin
        send_next(CMD_PRESS, CLS_THUMB, stray);
        tk = stray;
      end
    end
    if ($urandom_range(5) == 0) send_next(CMD_RELEASE, 2'($urandom_range(1, 3)), any_code());
    case ($urandom_range(5))
      0: send_next(CMD_CLEAR, 2'($urandom_range(3)), any_code());
      1, 2: begin
        send_next(CMD_RELEASE, 2'($urandom_range(1, 3)), ck);
        send_next(CMD_RELEASE, 2'($urandom_range(1, 3)), tk);
      end
      3, 4: begin
        send_next(CMD_RELEASE, 2'($urandom_range(1, 3)), tk);
        send_next(CMD_RELEASE, 2'($urandom_range(1, 3)), ck);
      end
      default: send_next(CMD_RELEASE, 2'($urandom_range(1, 3)), thumb_first ? tk : ck);
    endcase
  endtask

  task automatic directed_chords();
    send_at(CMD_PRESS, CLS_OUTSIDE, 16'h0000, 16'd0);
    send_at(CMD_RELEASE, CLS_OTHER, 16'h1234, 16'd5);
    send_at(CMD_TIMER, CLS_OUTSIDE, 16'h0000, 16'd10);
    send_at(CMD_PRESS, CLS_CHAR, 16'hFFFF, 16'd100);
    send_at(CMD_TIMER, CLS_CHAR, 16'hFFFF, 16'd120);
    send_at(CMD_PRESS, CLS_THUMB, 16'h0001, 16'd125);
    send_at(CMD_RELEASE, CLS_CHAR, 16'hFFFF, 16'd130);
    send_at(CMD_RELEASE, CLS_THUMB, 16'h0001, 16'd200);
    send_at(CMD_PRESS, CLS_THUMB, 16'h8001, 16'd300);
    // Nine other-key requests: eight fill the buffer and the last one is dropped.
    for (int i = 0; i < 9; i++) begin
      send_at(i[0] ? CMD_RELEASE : CMD_PRESS, i[0] ? CLS_OUTSIDE : CLS_OTHER,
              16'hA5A5 ^ 16'(i), 16'(301 + i));
    end
    send_at(CMD_PRESS, CLS_CHAR, 16'h7FFE, 16'd330);
    send_at(CMD_PRESS, CLS_THUMB, 16'h4000, 16'd340);
    send_at(CMD_RELEASE, CLS_CHAR, 16'h1111, 16'd345);
    send_at(CMD_CLEAR, CLS_OTHER, 16'hFFFF, 16'hFFFF);
    send_at(CMD_PRESS, CLS_CHAR, 16'h2222, 16'hFFFF);
    send_at(CMD_PRESS, CLS_THUMB, 16'h3333, 16'd150);
    send_at(CMD_RELEASE, CLS_THUMB, 16'h3333, 16'd400);
  endtask

  initial begin : stimulus
    int          goal;
    logic [15:0] ovl_cfg;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          tmo_cfg = TIMEOUT_RESET;
          ovl_cfg = OVERLAP_RESET;
        end
        1: begin
          idle_pct = 75;
          stall_pct = 0;
          tmo_cfg = 16'd0;
          ovl_cfg = 16'hFFFF;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 75;
          tmo_cfg = 16'hFFFF;
          ovl_cfg = 16'd0;
        end
        default: begin
          idle_pct = 38;
          stall_pct = 38;
          tmo_cfg = 16'($urandom_range(50, 400));
          ovl_cfg = 16'($urandom_range(5, 80));
        end
      endcase
      apb_access(1'b1, REG_TIMEOUT, tmo_cfg);
      apb_access(1'b1, REG_OVERLAP, ovl_cfg);
      apb_access(1'b0, REG_TIMEOUT, '0);
      apb_access(1'b0, REG_OVERLAP, '0);
      if (p == 0) directed_chords();
      goal = requests_sent + PHASE_ITEMS;
      while (requests_sent < goal) play_chord();
    end
    wait_idle();
    $display("Sent %0d key, timer and clear requests over four idle and stall mixes,", requests_sent);
    $display("with timeouts from zero to the maximum; %0d results compared.", results_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("thumb_shift_chord_judge_unit: match");
    end else begin
      $display("thumb_shift_chord_judge_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ thumb_shift_chord_judge_unit.f @@
sv/tscj_pkg.sv
sv/tscj_ram.sv
sv/tscj_ctrl.sv
sv/tscj_dp.sv
sv/thumb_shift_chord_judge_unit.sv
dv/tscj_judge_checker.sv
dv/tb_top.sv
